FILE: design/rnpr_pkg.sv
package rnpr_pkg;

    // Fixed field widths
    localparam int RANK_W = 41;
    localparam int POS_W  = 4;
    localparam int CFG_W  = 5;

    // Ring size limits and reset value
    localparam logic [CFG_W-1:0] RING_MIN   = 5'd3;
    localparam logic [CFG_W-1:0] RING_RESET = 5'd16;

    // Conditional subtractions needed to reduce a 4-bit place by a ring of at least 3
    localparam int MOD_STEPS = 5;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_USE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // take one input beat
        logic read;      // issue table reads at walk pointers
        logic use_data;  // fold read data into rank, swap tables, advance
        logic out_load;  // move finished rank into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_item;
        logic top_is_one;
    } sts_t;

endpackage

FILE: design/rnpr_ctrl.sv
module rnpr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rnpr_pkg::sts_t sts,
    output rnpr_pkg::cmd_t cmd
);

    rnpr_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rnpr_pkg::ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            rnpr_pkg::ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && sts.last_item) begin
                    state_next = rnpr_pkg::ST_READ;
                end
            end
            rnpr_pkg::ST_READ: begin
                cmd.read   = 1'b1;
                state_next = rnpr_pkg::ST_USE;
            end
            rnpr_pkg::ST_USE: begin
                cmd.use_data = 1'b1;
                state_next   = sts.top_is_one ? rnpr_pkg::ST_DONE : rnpr_pkg::ST_READ;
            end
            rnpr_pkg::ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = rnpr_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = rnpr_pkg::ST_LOAD;
            end
        endcase
    end

    // Output beat valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: design/rnpr_dp.sv
module rnpr_dp #(
    parameter int MAX_RING = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rnpr_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic [rnpr_pkg::POS_W-1:0]       s_tile_position,
    output logic [rnpr_pkg::RANK_W-1:0]      m_rank,
    input  rnpr_pkg::cmd_t                   cmd,
    output rnpr_pkg::sts_t                   sts
);

    localparam int NW = $clog2(MAX_RING + 1);
    localparam int AW = $clog2(MAX_RING);
    localparam int CW = (NW > rnpr_pkg::POS_W) ? NW : rnpr_pkg::POS_W;
    localparam int RW = rnpr_pkg::RANK_W;

    logic [rnpr_pkg::CFG_W-1:0] ring_size_reg;
    logic [NW-1:0]              count_reg;
    logic [AW-1:0]              offset_reg;
    logic [AW-1:0]              pos_reg;
    logic [AW-1:0]              top_reg;
    logic                       first_reg;
    logic [RW-1:0]              rank_reg;
    logic [RW-1:0]              m_rank_reg;
    logic [AW-1:0]              ea_rd_reg;
    logic [AW-1:0]              iov_rd_reg;

    logic [AW-1:0] ea_mem  [MAX_RING];
    logic [AW-1:0] iov_mem [MAX_RING];

    logic [rnpr_pkg::CFG_W-1:0] n_wide;
    logic [NW-1:0]              n_eff;
    logic [CW-1:0]              place_wide;
    logic [AW-1:0]              place;
    logic [NW-1:0]              offset_full;
    logic [NW:0]                rot_sum;
    logic [AW-1:0]              rot_val;
    logic [AW-1:0]              slot;
    logic [NW-1:0]              mult;
    logic [RW+NW-1:0]           prod;
    logic [RW-1:0]              rank_next;

    // Saturate ring size to the supported range
    always_comb begin
        if (ring_size_reg < rnpr_pkg::RING_MIN) begin
            n_wide = rnpr_pkg::RING_MIN;
        end else if (ring_size_reg > rnpr_pkg::CFG_W'(MAX_RING)) begin
            n_wide = rnpr_pkg::CFG_W'(MAX_RING);
        end else begin
            n_wide = ring_size_reg;
        end
        n_eff = n_wide[NW-1:0];
    end

    // Reduce the incoming place modulo the ring size
    always_comb begin
        place_wide = CW'(s_tile_position);
        for (int i = 0; i < rnpr_pkg::MOD_STEPS; i++) begin
            if (place_wide >= CW'(n_eff)) begin
                place_wide = place_wide - CW'(n_eff);
            end
        end
        place = place_wide[AW-1:0];
    end

    // Rotation that puts tile 0 at the last place, and the rotated value
    always_comb begin
        offset_full = n_eff - NW'(1) - NW'(place);
        rot_sum     = (NW+1)'(place) + (NW+1)'(offset_reg);
        if (rot_sum >= (NW+1)'(n_eff)) begin
            rot_sum = rot_sum - (NW+1)'(n_eff);
        end
        rot_val = rot_sum[AW-1:0];
        slot    = AW'(count_reg - NW'(1));
    end

    assign sts.last_item  = (count_reg != '0) &&
                            ((NW+1)'(count_reg) + (NW+1)'(1) >= (NW+1)'(n_eff));
    assign sts.top_is_one = (top_reg == AW'(1));

    // Rank step: multiply by remaining count and add the new leading element
    always_comb begin
        mult      = n_eff - NW'(1) - NW'(pos_reg);
        prod      = (RW+NW)'(rank_reg) * (RW+NW)'(mult);
        rank_next = first_reg ? RW'(ea_rd_reg) : (prod[RW-1:0] + RW'(ea_rd_reg));
    end

    // Control registers: ring size, frame count, walk pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg <= rnpr_pkg::RING_RESET;
            count_reg     <= '0;
            offset_reg    <= '0;
            pos_reg       <= '0;
            top_reg       <= '0;
            first_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            // Drop the current frame
            ring_size_reg <= cfg_wr_data;
            count_reg     <= '0;
        end else if (cmd.load) begin
            if (count_reg == '0) begin
                offset_reg <= offset_full[AW-1:0];
                count_reg  <= NW'(1);
            end else if (sts.last_item) begin
                count_reg <= '0;
                pos_reg   <= '0;
                top_reg   <= AW'(n_eff - NW'(2));
                first_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + NW'(1);
            end
        end else if (cmd.use_data) begin
            first_reg <= 1'b0;
            if (!sts.top_is_one) begin
                pos_reg <= pos_reg + AW'(1);
                top_reg <= top_reg - AW'(1);
            end
        end
    end

    // Rank accumulator and output register
    always_ff @(posedge aclk) begin
        if (cmd.use_data) begin
            rank_reg <= rank_next;
        end
        if (cmd.out_load) begin
            m_rank_reg <= rank_reg;
        end
    end

    // Tables: load writes, swap writes during the walk, registered reads
    always_ff @(posedge aclk) begin
        if (cmd.load && count_reg != '0) begin
            ea_mem[slot]     <= rot_val;
            iov_mem[rot_val] <= slot;
        end else if (cmd.use_data && !sts.top_is_one) begin
            ea_mem[iov_rd_reg] <= ea_rd_reg;
            iov_mem[ea_rd_reg] <= iov_rd_reg;
        end
        if (cmd.read) begin
            ea_rd_reg  <= ea_mem[pos_reg];
            iov_rd_reg <= iov_mem[top_reg];
        end
    end

    assign m_rank = m_rank_reg;

endmodule

FILE: design/rotation_normalized_permutation_rank.sv
// Rotation-normalized permutation rank. Feed the places of tiles 0 to N-1 in
// order, one beat per cycle (N is ring_size saturated to 3..MAX_RING, places
// taken modulo N). Tile 0 fixes a rotation that puts it at the last place; the
// other N-1 rotated places form a permutation that is ranked with swap-removal
// ranking into 0..(N-1)!-1 (low 41 bits). After the last beat of a frame the
// input stalls while the walk runs: each swap step has a read state and an
// update state, since the two single-port tables must see the previous swap
// before the next lookup. The result sits in an output register, so the next
// frame loads while it waits. Writing ring_size drops a partly loaded frame.
// The input is assumed to be a valid permutation and is not checked.
module rotation_normalized_permutation_rank #(
    parameter int MAX_RING = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rnpr_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rnpr_pkg::POS_W-1:0]  s_tile_position,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rnpr_pkg::RANK_W-1:0] m_rank
);

    rnpr_pkg::cmd_t cmd;
    rnpr_pkg::sts_t sts;

    // Sequencer
    rnpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Tables and rank arithmetic
    rnpr_dp #(
        .MAX_RING (MAX_RING)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tile_position (s_tile_position),
        .m_rank          (m_rank),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule
